@@ rtl/diagonal_state_space_scan_defines.svh @@
// assertion macros used by diagonal_state_space_scan.sv
`ifndef DIAGONAL_STATE_SPACE_SCAN_DEFINES_SVH
`define DIAGONAL_STATE_SPACE_SCAN_DEFINES_SVH

// expr must never be true outside reset
`define DSS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// ante implies cons in the same cycle
`define DSS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/dss_pkg.sv @@
package dss_pkg;

   localparam int unsigned CHANNELS_DEF = 64;
   localparam int unsigned PAIRS_DEF    = 32;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned PROD_W = 64;
   localparam int unsigned RND_W  = PROD_W - 16;
   localparam int unsigned COEF_W = 6 * DATA_W;
   localparam int unsigned XST_W  = 2 * DATA_W;

   localparam logic [1:0] MODE_LOAD_COEF = 2'd0;
   localparam logic [1:0] MODE_LOAD_GAIN = 2'd1;
   localparam logic [1:0] MODE_SAMPLE    = 2'd2;

   localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

   // one pair entering the arithmetic pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic zero;
   } issue_type;

   // q32.32 product to q32.16, round half up
   function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + 64'sd32768;
      return s[PROD_W-1:16];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[DATA_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/dss_ram.sv @@
module dss_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dss_pipe.sv @@
module dss_pipe #(
   parameter int unsigned CHANNELS    = dss_pkg::CHANNELS_DEF,
   parameter int unsigned STATE_PAIRS = dss_pkg::PAIRS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dss_pkg::issue_type                   s1,
   input  logic [((CHANNELS*STATE_PAIRS) > 1 ?
                  $clog2(CHANNELS*STATE_PAIRS) : 1)-1:0] s1_addr,
   input  logic [dss_pkg::COEF_W-1:0]           coef_rd,
   input  logic [dss_pkg::XST_W-1:0]            x_rd,
   input  logic [dss_pkg::DATA_W-1:0]           gain_rd,
   input  logic [dss_pkg::DATA_W-1:0]           sample,
   output logic                                 wb_we,
   output logic [((CHANNELS*STATE_PAIRS) > 1 ?
                  $clog2(CHANNELS*STATE_PAIRS) : 1)-1:0] wb_addr,
   output logic [dss_pkg::XST_W-1:0]            wb_data,
   output logic                                 done,
   output logic [dss_pkg::DATA_W-1:0]           y
);
   import dss_pkg::*;

   localparam int unsigned ENTRIES = CHANNELS * STATE_PAIRS;
   localparam int unsigned AW      = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
   localparam int unsigned ACC_W   = RND_W + 2 + $clog2(STATE_PAIRS);

   logic signed [DATA_W-1:0] ar, ai, br, bi, xr, xi, u, g;

   // stage 2
   logic                     v2_ff, first2_ff, last2_ff;
   logic [AW-1:0]            idx2_ff;
   logic signed [DATA_W-1:0] cr2_ff, ci2_ff;
   logic signed [PROD_W-1:0] p_arxr_ff, p_aixi_ff, p_bru_ff;
   logic signed [PROD_W-1:0] p_arxi_ff, p_aixr_ff, p_biu_ff, p_gu_ff;
   logic signed [DATA_W-1:0] nr_in, ni_in;
   // stage 3
   logic                     v3_ff, last3_ff;
   logic [AW-1:0]            idx3_ff;
   logic signed [DATA_W-1:0] nr3_ff, ni3_ff, cr3_ff, ci3_ff;
   // stage 4
   logic                     v4_ff, last4_ff;
   logic signed [PROD_W-1:0] p_cr_ff, p_ci_ff;
   logic signed [ACC_W-1:0]  term_in, acc_ff, acc_in;
   logic signed [RND_W-1:0]  gain_rnd_ff;
   logic                     done_ff;
   logic signed [DATA_W-1:0] y_ff, y_in;

   assign ar = coef_rd[0*DATA_W +: DATA_W];
   assign ai = coef_rd[1*DATA_W +: DATA_W];
   assign br = coef_rd[2*DATA_W +: DATA_W];
   assign bi = coef_rd[3*DATA_W +: DATA_W];
   assign xr = s1.zero ? '0 : x_rd[0 +: DATA_W];
   assign xi = s1.zero ? '0 : x_rd[DATA_W +: DATA_W];
   assign u  = sample;
   assign g  = gain_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v2_ff   <= s1.valid;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         done_ff <= v4_ff && last4_ff;
      end
   end

   always_ff @(posedge clock) begin
      first2_ff <= s1.first;
      last2_ff  <= s1.last;
      idx2_ff   <= s1_addr;
      cr2_ff    <= coef_rd[4*DATA_W +: DATA_W];
      ci2_ff    <= coef_rd[5*DATA_W +: DATA_W];
      p_arxr_ff <= ar * xr;
      p_aixi_ff <= ai * xi;
      p_bru_ff  <= br * u;
      p_arxi_ff <= ar * xi;
      p_aixr_ff <= ai * xr;
      p_biu_ff  <= bi * u;
      if (s1.valid && s1.first) begin
         p_gu_ff <= g * u;
      end
   end

   assign nr_in = sat32(PROD_W'(rnd(p_arxr_ff)) - PROD_W'(rnd(p_aixi_ff))
                        + PROD_W'(rnd(p_bru_ff)));
   assign ni_in = sat32(PROD_W'(rnd(p_arxi_ff)) + PROD_W'(rnd(p_aixr_ff))
                        + PROD_W'(rnd(p_biu_ff)));

   always_ff @(posedge clock) begin
      last3_ff <= last2_ff;
      idx3_ff  <= idx2_ff;
      nr3_ff   <= nr_in;
      ni3_ff   <= ni_in;
      cr3_ff   <= cr2_ff;
      ci3_ff   <= ci2_ff;
      if (v2_ff && first2_ff) begin
         gain_rnd_ff <= rnd(p_gu_ff);
      end
   end

   assign wb_we   = v3_ff;
   assign wb_addr = idx3_ff;
   assign wb_data = {ni3_ff, nr3_ff};

   always_ff @(posedge clock) begin
      last4_ff <= last3_ff;
      p_cr_ff  <= cr3_ff * nr3_ff;
      p_ci_ff  <= ci3_ff * ni3_ff;
   end

   // 2*re(c*x) for the pair leaving stage 4
   assign term_in = ACC_W'((PROD_W'(rnd(p_cr_ff)) - PROD_W'(rnd(p_ci_ff))) <<< 1);

   always_comb begin
      acc_in = acc_ff;
      if (v2_ff && first2_ff) begin
         acc_in = '0;
      end else if (v4_ff) begin
         acc_in = acc_ff + term_in;
      end
   end

   assign y_in = sat32(PROD_W'(acc_ff) + PROD_W'(term_in) + PROD_W'(gain_rnd_ff));

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (v4_ff && last4_ff) begin
         y_ff <= y_in;
      end
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule

@@ rtl/diagonal_state_space_scan.sv @@
// channel | direction | handshake           | payload
// req     | in        | req_tvalid/tready   | tuser: mode, seq_start; tdata: item fields
// rsp     | out       | rsp_tvalid/tready   | tdata: out_channel, y_out
//
// after acceptance a sample is processed up to rsp_tvalid as follows: one state
// pair per cycle through the single read port of the coefficient and state memories,
// then the pipeline drains and the output register is loaded. a load is written on acceptance.
// after reset a clearing pass over all CHANNELS*STATE_PAIRS entries zeroes the state memory
// with req_tready low. a waiting result sits in the output register, so new items
// are taken while rsp is stalled; a finished sample waits until that register frees.
`include "diagonal_state_space_scan_defines.svh"

module diagonal_state_space_scan #(
   parameter int unsigned CHANNELS    = dss_pkg::CHANNELS_DEF,
   parameter int unsigned STATE_PAIRS = dss_pkg::PAIRS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0], seq_start[2]
   input  logic [2:0]   req_tuser,
   // channel[5:0], state_index[10:6], coef_ar[42:11], coef_ai[74:43],
   // coef_br[106:75], coef_bi[138:107], coef_cr[170:139], coef_ci[202:171],
   // feedthrough[234:203], sample[266:235], zero fill[271:267]
   input  logic [271:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_channel[5:0], y_out[37:6], zero fill[39:38]
   output logic [39:0]  rsp_tdata
);
   import dss_pkg::*;

   localparam int unsigned ENTRIES = CHANNELS * STATE_PAIRS;
   localparam int unsigned AW      = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
   localparam int unsigned GW      = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int unsigned PW      = STATE_PAIRS > 1 ? $clog2(STATE_PAIRS) : 1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]        req_mode;
   logic              req_start;
   logic [5:0]        req_channel;
   logic [4:0]        req_state_index;
   logic [DATA_W-1:0] req_feedthrough, req_sample;
   logic              req_fire, ch_ok, si_ok;

   logic [AW-1:0]     clr_ff, clr_in;
   logic [PW-1:0]     pair_ff, pair_in;
   logic [5:0]        ch_ff;
   logic [DATA_W-1:0] sample_ff;
   logic              start_ff;
   logic              pair_last;
   logic [AW-1:0]     issue_addr, load_addr;

   issue_type         s1_ff, s1_in;
   logic [AW-1:0]     s1_addr_ff;

   logic              coef_we, gain_we;
   logic [COEF_W-1:0] coef_rd;
   logic [DATA_W-1:0] gain_rd;
   logic [XST_W-1:0]  x_rd;
   logic              x_we;
   logic [AW-1:0]     x_waddr;
   logic [XST_W-1:0]  x_wdata;

   logic              wb_we;
   logic [AW-1:0]     wb_addr;
   logic [XST_W-1:0]  wb_data;
   logic              done;
   logic [DATA_W-1:0] y;

   logic              rsp_tvalid_ff, rsp_tvalid_in, rsp_load;
   logic [5:0]        rsp_channel_ff;
   logic [DATA_W-1:0] rsp_y_ff;

   assign req_mode        = req_tuser[1:0];
   assign req_start       = req_tuser[2];
   assign req_channel     = req_tdata[5:0];
   assign req_state_index = req_tdata[10:6];
   assign req_feedthrough = req_tdata[234:203];
   assign req_sample      = req_tdata[266:235];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign ch_ok      = 32'(req_channel) < 32'(CHANNELS);
   assign si_ok      = 32'(req_state_index) < 32'(STATE_PAIRS);

   assign load_addr  = AW'(req_channel) * AW'(STATE_PAIRS) + AW'(req_state_index);
   assign issue_addr = AW'(ch_ff) * AW'(STATE_PAIRS) + AW'(pair_ff);
   assign pair_last  = (pair_ff == PW'(STATE_PAIRS - 1));

   assign coef_we = req_fire && (req_mode == MODE_LOAD_COEF) && ch_ok && si_ok;
   assign gain_we = req_fire && (req_mode == MODE_LOAD_GAIN) && ch_ok;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pair_in  = pair_ff;
      rsp_load = 1'b0;
      s1_in    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_mode == MODE_SAMPLE) && ch_ok) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            s1_in.valid = 1'b1;
            s1_in.first = (pair_ff == '0);
            s1_in.last  = pair_last;
            s1_in.zero  = start_ff;
            pair_in     = pair_ff + PW'(1);
            if (pair_last) begin
               pair_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         pair_ff       <= '0;
         s1_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pair_ff       <= pair_in;
         s1_ff         <= s1_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= issue_addr;
      if (req_fire) begin
         ch_ff     <= req_channel;
         sample_ff <= req_sample;
         start_ff  <= req_start;
      end
      if (rsp_load) begin
         rsp_channel_ff <= ch_ff;
         rsp_y_ff       <= y;
      end
   end

   // clearing pass owns the state write port until it ends
   assign x_we    = (state_ff == ST_CLEAR) || wb_we;
   assign x_waddr = (state_ff == ST_CLEAR) ? clr_ff : wb_addr;
   assign x_wdata = (state_ff == ST_CLEAR) ? '0 : wb_data;

   dss_ram #(.WIDTH(COEF_W), .DEPTH(ENTRIES)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (load_addr),
      .wr_data (req_tdata[202:11]),
      .rd_addr (issue_addr),
      .rd_data (coef_rd)
   );

   dss_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_gain_ram (
      .clock   (clock),
      .wr_en   (gain_we),
      .wr_addr (GW'(req_channel)),
      .wr_data (req_feedthrough),
      .rd_addr (GW'(ch_ff)),
      .rd_data (gain_rd)
   );

   dss_ram #(.WIDTH(XST_W), .DEPTH(ENTRIES)) u_state_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (x_waddr),
      .wr_data (x_wdata),
      .rd_addr (issue_addr),
      .rd_data (x_rd)
   );

   dss_pipe #(.CHANNELS(CHANNELS), .STATE_PAIRS(STATE_PAIRS)) u_pipe (
      .clock   (clock),
      .reset   (reset),
      .s1      (s1_ff),
      .s1_addr (s1_addr_ff),
      .coef_rd (coef_rd),
      .x_rd    (x_rd),
      .gain_rd (gain_rd),
      .sample  (sample_ff),
      .wb_we   (wb_we),
      .wb_addr (wb_addr),
      .wb_data (wb_data),
      .done    (done),
      .y       (y)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_y_ff, rsp_channel_ff};

   `DSS_ASSERT_NEVER(a_wb_during_clear, clock, reset, wb_we && (state_ff == ST_CLEAR), "state write-back during clearing pass")
   `DSS_ASSERT_IMPLY(a_done_in_drain, clock, reset, done, state_ff == ST_DRAIN, "pipeline result outside drain")
   `DSS_ASSERT_IMPLY(a_pair_idle_zero, clock, reset, state_ff == ST_IDLE, pair_ff == '0, "pair counter not rewound")

endmodule
